@@ rtl/core/sactl_pkg.sv @@
// Shared types and constants for the set-associative tag cache.
package sactl_pkg;

  localparam int ADDR_BITS = 32;
  localparam int LEN_BITS  = 8;
  localparam int TICK_BITS = 48;

  localparam logic [1:0] SRC_REQ  = 2'd0;
  localparam logic [1:0] SRC_FILL = 2'd1;
  localparam logic [1:0] SRC_PEND = 2'd2;

  typedef struct packed {
    logic       load;
    logic       lk_start;
    logic       lk_cmp;
    logic [1:0] src;
    logic       req_act;
    logic       fill_act;
    logic       scan_start;
    logic       pend_next;
    logic       pend_take;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_bad;
    logic fill_valid;
    logic hit;
    logic way_last;
    logic pend_more;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/sactl_if.sv @@
// Tick input and result output channel interfaces.
interface sactl_in_if;
  logic                            valid;
  logic                            ready;
  logic                            req_valid;
  logic                            req_write;
  logic [sactl_pkg::ADDR_BITS-1:0] req_addr;
  logic [sactl_pkg::LEN_BITS-1:0]  req_length;
  logic                            fill_valid;
  logic [sactl_pkg::ADDR_BITS-1:0] fill_addr;

  modport source (output valid, req_valid, req_write, req_addr, req_length, fill_valid,
                  fill_addr, input ready);
  modport sink (input valid, req_valid, req_write, req_addr, req_length, fill_valid,
                fill_addr, output ready);
endinterface

interface sactl_out_if;
  logic                            valid;
  logic                            ready;
  logic                            resp_valid;
  logic                            resp_write;
  logic [sactl_pkg::ADDR_BITS-1:0] resp_addr;
  logic [sactl_pkg::LEN_BITS-1:0]  resp_length;
  logic                            resp_error;
  logic                            fetch_valid;
  logic                            fetch_write;
  logic [sactl_pkg::ADDR_BITS-1:0] fetch_addr;

  modport source (output valid, resp_valid, resp_write, resp_addr, resp_length, resp_error,
                  fetch_valid, fetch_write, fetch_addr, input ready);
  modport sink (input valid, resp_valid, resp_write, resp_addr, resp_length, resp_error,
                fetch_valid, fetch_write, fetch_addr, output ready);
endinterface

@@ rtl/core/sactl_ctrl.sv @@
// Sequencing state machine for one cache tick.
module sactl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sactl_pkg::sts_t   sts,
  output sactl_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LKRD  = 3'd2;
  localparam logic [2:0] S_LKCMP = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_FCHK  = 3'd5;
  localparam logic [2:0] S_PCHK  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state, state_next;
  logic [1:0] phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= sactl_pkg::SRC_REQ;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    cmd.src    = phase;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.req_valid) begin
          state_next = S_FCHK;
        end else if (sts.req_bad) begin
          cmd.req_act = 1'b1;
          state_next  = S_FCHK;
        end else begin
          cmd.lk_start = 1'b1;
          cmd.src      = sactl_pkg::SRC_REQ;
          phase_next   = sactl_pkg::SRC_REQ;
          state_next   = S_LKRD;
        end
      end
      S_LKRD: state_next = S_LKCMP;
      S_LKCMP: begin
        cmd.lk_cmp = 1'b1;
        state_next = sts.way_last ? S_ACT : S_LKRD;
      end
      S_ACT: begin
        case (phase)
          sactl_pkg::SRC_REQ: begin
            cmd.req_act = 1'b1;
            state_next  = S_FCHK;
          end
          sactl_pkg::SRC_FILL: begin
            cmd.fill_act   = 1'b1;
            cmd.scan_start = 1'b1;
            state_next     = S_PCHK;
          end
          default: begin
            if (sts.hit) begin
              cmd.pend_take = 1'b1;
              state_next    = S_DONE;
            end else begin
              cmd.pend_next = 1'b1;
              state_next    = S_PCHK;
            end
          end
        endcase
      end
      S_FCHK: begin
        if (sts.fill_valid) begin
          cmd.lk_start = 1'b1;
          cmd.src      = sactl_pkg::SRC_FILL;
          phase_next   = sactl_pkg::SRC_FILL;
          state_next   = S_LKRD;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_PCHK;
        end
      end
      S_PCHK: begin
        if (sts.pend_more) begin
          cmd.lk_start = 1'b1;
          cmd.src      = sactl_pkg::SRC_PEND;
          phase_next   = sactl_pkg::SRC_PEND;
          state_next   = S_LKRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/sactl_dpath.sv @@
// Tag store, line valid bits, pending queue, way lookup and result registers.
module sactl_dpath #(
  parameter int ROWS          = 64,
  parameter int WAYS          = 4,
  parameter int LINE_BYTES    = 64,
  parameter int PENDING_DEPTH = 8,
  parameter int AGE_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  sactl_pkg::cmd_t   cmd,
  output sactl_pkg::sts_t   sts,
  sactl_in_if.sink          tick,
  sactl_out_if.source       result
);

  localparam int AW  = sactl_pkg::ADDR_BITS;
  localparam int LNW = sactl_pkg::LEN_BITS;
  localparam int TB  = sactl_pkg::TICK_BITS;
  localparam int OB  = $clog2(LINE_BYTES);
  localparam int RB  = $clog2(ROWS);
  localparam int RBW = (RB > 0) ? RB : 1;
  localparam int TW  = AW - OB - RB;
  localparam int NL  = ROWS * WAYS;
  localparam int LW  = (NL > 1) ? $clog2(NL) : 1;
  localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW  = $clog2(PENDING_DEPTH + 1);
  localparam logic [TB-1:0] AGE_MAX = TB'((64'd1 << AGE_BITS) - 64'd1);

  function automatic logic [RBW-1:0] row_of(input logic [AW-1:0] a);
    logic [RBW-1:0] f;
    f = '0;
    if (RB > 0) begin
      f = a[OB +: RBW];
      if ({1'b0, f} >= (RBW+1)'(ROWS)) f = f - RBW'(ROWS);
    end
    return f;
  endfunction

  function automatic logic [LW-1:0] line_of(input logic [AW-1:0] a, input logic [WW-1:0] w);
    return LW'(LW'(row_of(a)) * LW'(WAYS)) + LW'(w);
  endfunction

  function automatic logic [TW-1:0] tag_of(input logic [AW-1:0] a);
    return a[OB+RB +: TW];
  endfunction

  // captured tick
  logic            rv, rw, fv;
  logic [AW-1:0]   ra, fa;
  logic [LNW-1:0]  rl;
  logic [TB-1:0]   now;

  // line store
  logic [TW+TB-1:0] mem [NL];
  logic [TW+TB-1:0] rdata;
  logic [NL-1:0]    lvalid;
  logic             we;
  logic [LW-1:0]    waddr;
  logic [TW+TB-1:0] wdata;

  // pending queue
  logic           pq_w [PENDING_DEPTH];
  logic [AW-1:0]  pq_a [PENDING_DEPTH];
  logic [LNW-1:0] pq_l [PENDING_DEPTH];
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  sidx;

  // lookup
  logic [1:0]     src;
  logic [WW-1:0]  way;
  logic           hit;
  logic [WW-1:0]  hit_way;
  logic           empty_found;
  logic [WW-1:0]  empty_way;
  logic [WW-1:0]  oldest_way;
  logic [AGE_BITS-1:0] oldest_age;
  logic [AW-1:0]  lk_addr;
  logic [LW-1:0]  lk_line;
  logic           lk_valid;
  logic           lk_match;
  logic [TB-1:0]  age_diff;
  logic [AGE_BITS-1:0] lk_age;

  // result
  logic           r_rv, r_rw, r_err, r_fv, r_fw;
  logic [AW-1:0]  r_ra, r_fa;
  logic [LNW-1:0] r_rl;
  logic           ovalid;

  logic [AW:0]    last_byte;
  logic           bad;

  assign last_byte = {1'b0, ra} + (AW+1)'(rl) - (AW+1)'(1);
  assign bad = (rl == '0) || ({1'b0, rl} > (LNW+1)'(LINE_BYTES)) ||
               (({1'b0, ra} >> OB) != (last_byte >> OB));

  always_comb begin
    case (src)
      sactl_pkg::SRC_REQ:  lk_addr = ra;
      sactl_pkg::SRC_FILL: lk_addr = fa;
      default:             lk_addr = pq_a[sidx[PW-1:0]];
    endcase
  end

  assign lk_line  = line_of(lk_addr, way);
  assign lk_valid = lvalid[lk_line];
  assign lk_match = lk_valid && (rdata[TW+TB-1:TB] == tag_of(lk_addr));
  assign age_diff = now - rdata[TB-1:0];
  assign lk_age   = !lk_valid ? '0 :
                    (age_diff > AGE_MAX) ? AGE_MAX[AGE_BITS-1:0] : age_diff[AGE_BITS-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = line_of(ra, hit_way);
    wdata = {tag_of(ra), now};
    if (cmd.req_act && !bad && hit) begin
      we = 1'b1;
    end else if (cmd.fill_act && !hit) begin
      we    = 1'b1;
      waddr = line_of(fa, empty_found ? empty_way : oldest_way);
      wdata = {tag_of(fa), now};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[lk_line];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
    end else if (cmd.fill_act && !hit) begin
      lvalid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (cmd.load) begin
      now <= now + TB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rv <= tick.req_valid;
      rw <= tick.req_write;
      ra <= tick.req_addr;
      rl <= tick.req_length;
      fv <= tick.fill_valid;
      fa <= tick.fill_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lk_start) begin
      src         <= cmd.src;
      way         <= '0;
      hit         <= 1'b0;
      hit_way     <= '0;
      empty_found <= 1'b0;
      empty_way   <= '0;
      oldest_way  <= '0;
      oldest_age  <= '0;
    end else if (cmd.lk_cmp) begin
      way <= way + WW'(1);
      if (lk_match && !hit) begin
        hit     <= 1'b1;
        hit_way <= way;
      end
      if (!lk_valid && !empty_found) begin
        empty_found <= 1'b1;
        empty_way   <= way;
      end
      if (lk_age > oldest_age) begin
        oldest_age <= lk_age;
        oldest_way <= way;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.req_act && !bad && !hit && cnt != CW'(PENDING_DEPTH)) begin
      cnt <= cnt + CW'(1);
    end else if (cmd.pend_take) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_act && !bad && !hit && cnt != CW'(PENDING_DEPTH)) begin
      pq_w[cnt[PW-1:0]] <= rw;
      pq_a[cnt[PW-1:0]] <= ra;
      pq_l[cnt[PW-1:0]] <= rl;
    end else if (cmd.pend_take) begin
      for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
        if (CW'(i) >= sidx) begin
          pq_w[i] <= pq_w[i+1];
          pq_a[i] <= pq_a[i+1];
          pq_l[i] <= pq_l[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sidx <= '0;
    end else if (cmd.pend_next) begin
      sidx <= sidx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {r_rv, r_rw, r_ra, r_rl, r_err, r_fv, r_fw, r_fa} <= '0;
    end else if (cmd.req_act) begin
      if (bad || hit || cnt == CW'(PENDING_DEPTH)) begin
        r_rv  <= 1'b1;
        r_rw  <= rw;
        r_ra  <= ra;
        r_rl  <= rl;
        r_err <= bad || !hit;
      end else begin
        r_fv <= 1'b1;
        r_fw <= rw;
        r_fa <= ra & ~AW'((64'd1 << OB) - 64'd1);
      end
    end else if (cmd.pend_take) begin
      r_rv  <= 1'b1;
      r_rw  <= pq_w[sidx[PW-1:0]];
      r_ra  <= pq_a[sidx[PW-1:0]];
      r_rl  <= pq_l[sidx[PW-1:0]];
      r_err <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.resp_valid  <= r_rv;
      result.resp_write  <= r_rw;
      result.resp_addr   <= r_ra;
      result.resp_length <= r_rl;
      result.resp_error  <= r_err;
      result.fetch_valid <= r_fv;
      result.fetch_write <= r_fw;
      result.fetch_addr  <= r_fa;
    end
  end

  assign result.valid = ovalid;

  assign sts.req_valid  = rv;
  assign sts.req_bad    = bad;
  assign sts.fill_valid = fv;
  assign sts.hit        = hit;
  assign sts.way_last   = (way == WW'(WAYS - 1));
  assign sts.pend_more  = (sidx < cnt);
  assign sts.out_free   = !ovalid || result.ready;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(PENDING_DEPTH))
    else $error("pending count above depth");

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pend_take |-> (cnt != '0) && (sidx < cnt))
    else $error("pending removal outside filled entries");

endmodule

@@ rtl/core/set_assoc_cache_tag_lru.sv @@
// Top level of the set-associative tag cache with oldest-way replacement.
// Each tick runs the request check, then a way-by-way lookup for a well-formed request and one
// for a fill, then a lookup per queued entry until one is answered or the queue is scanned.
// A malformed request needs no lookup; a stalled result holds the controller until taken.
// Throughput: one tick at a time, next accept in the cycle after the result loads.
// Reset: line valid bits, queue count, tick counter and output valid clear at once.
module set_assoc_cache_tag_lru #(
  parameter int ROWS          = 64,
  parameter int WAYS          = 4,
  parameter int LINE_BYTES    = 64,
  parameter int PENDING_DEPTH = 8,
  parameter int AGE_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  sactl_in_if.sink    tick,
  sactl_out_if.source result
);

  sactl_pkg::cmd_t cmd;
  sactl_pkg::sts_t sts;

  sactl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .in_ready (tick.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sactl_dpath #(
    .ROWS          (ROWS),
    .WAYS          (WAYS),
    .LINE_BYTES    (LINE_BYTES),
    .PENDING_DEPTH (PENDING_DEPTH),
    .AGE_BITS      (AGE_BITS)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .tick   (tick),
    .result (result)
  );

  a_fetch_no_err: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.fetch_valid |-> !result.resp_error)
    else $error("fetch issued with error response");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.resp_valid |-> !result.resp_error && result.resp_addr == '0)
    else $error("response fields set without response");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the set-associative tag cache: directed table then random ticks.
`timescale 1ns / 1ps
module tb_top;

  localparam int ROWS = 64;
  localparam int WAYS = 4;
  localparam int LINE_BYTES = 64;
  localparam int PENDING_DEPTH = 8;
  localparam int AGE_BITS = 16;
  localparam int OB = 6;
  localparam int RB = 6;
  localparam int NLINES = ROWS * WAYS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam int N_RANDOM = 750;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic                            req_valid;
    logic                            req_write;
    logic [sactl_pkg::ADDR_BITS-1:0] req_addr;
    logic [sactl_pkg::LEN_BITS-1:0]  req_length;
    logic                            fill_valid;
    logic [sactl_pkg::ADDR_BITS-1:0] fill_addr;
  } tick_t;

  typedef struct packed {
    logic                            resp_valid;
    logic                            resp_write;
    logic [sactl_pkg::ADDR_BITS-1:0] resp_addr;
    logic [sactl_pkg::LEN_BITS-1:0]  resp_length;
    logic                            resp_error;
    logic                            fetch_valid;
    logic                            fetch_write;
    logic [sactl_pkg::ADDR_BITS-1:0] fetch_addr;
  } outcome_t;

  typedef struct packed {
    logic                            write;
    logic [sactl_pkg::ADDR_BITS-1:0] addr;
    logic [sactl_pkg::LEN_BITS-1:0]  length;
  } miss_t;

  typedef struct {
    tick_t    t;
    logic     typed;
    outcome_t o;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  sactl_in_if  tick_ch();
  sactl_out_if res_ch();

  set_assoc_cache_tag_lru #(
    .ROWS(ROWS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES),
    .PENDING_DEPTH(PENDING_DEPTH), .AGE_BITS(AGE_BITS)
  ) i_dut (
    .clk(clk), .rst(rst), .tick(tick_ch.sink), .result(res_ch.source)
  );

  logic                lv [NLINES];
  logic [31-OB-RB:0]   lt [NLINES];
  logic [AGE_BITS-1:0] la [NLINES];
  miss_t               miss_q[$];
  outcome_t            outcome_q[$];
  int                  errors = 0;
  longint              cycles = 0;
  logic                draining = 1'b0;

  function automatic int set_base(logic [31:0] a);
    return int'(a[OB+RB-1:OB]) * WAYS;
  endfunction

  function automatic int lookup(logic [31:0] a);
    int b;
    b = set_base(a);
    for (int w = 0; w < WAYS; w++)
      if (lv[b+w] && lt[b+w] == a[31:OB+RB]) return w;
    return -1;
  endfunction

  function automatic outcome_t cache_tick(tick_t t);
    outcome_t o;
    logic [32:0] last;
    int w, b, dest;
    o = '0;
    for (int i = 0; i < NLINES; i++)
      if (lv[i] && la[i] != AGE_MAX) la[i]++;
    if (t.req_valid) begin
      last = {1'b0, t.req_addr} + 33'(t.req_length) - 33'd1;
      if (t.req_length == 0 || t.req_length > LINE_BYTES ||
          ({1'b0, t.req_addr} >> OB) != (last >> OB)) begin
        o.resp_valid = 1; o.resp_write = t.req_write; o.resp_addr = t.req_addr;
        o.resp_length = t.req_length; o.resp_error = 1;
      end else begin
        w = lookup(t.req_addr);
        if (w >= 0) begin
          la[set_base(t.req_addr)+w] = '0;
          o.resp_valid = 1; o.resp_write = t.req_write; o.resp_addr = t.req_addr;
          o.resp_length = t.req_length;
        end else if (miss_q.size() >= PENDING_DEPTH) begin
          o.resp_valid = 1; o.resp_write = t.req_write; o.resp_addr = t.req_addr;
          o.resp_length = t.req_length; o.resp_error = 1;
        end else begin
          miss_q.insert(miss_q.size(), '{t.req_write, t.req_addr, t.req_length});
          o.fetch_valid = 1; o.fetch_write = t.req_write;
          o.fetch_addr = {t.req_addr[31:OB], {OB{1'b0}}};
        end
      end
    end
    if (t.fill_valid && lookup(t.fill_addr) < 0) begin
      b = set_base(t.fill_addr);
      dest = -1;
      for (int i = 0; i < WAYS; i++)
        if (dest < 0 && !lv[b+i]) dest = i;
      if (dest < 0) begin
        dest = 0;
        for (int i = 1; i < WAYS; i++)
          if (la[b+dest] < la[b+i]) dest = i;
      end
      lv[b+dest] = 1; lt[b+dest] = t.fill_addr[31:OB+RB]; la[b+dest] = '0;
    end
    for (int i = 0; i < miss_q.size(); i++) begin
      if (lookup(miss_q[i].addr) >= 0) begin
        o.resp_valid = 1; o.resp_write = miss_q[i].write; o.resp_addr = miss_q[i].addr;
        o.resp_length = miss_q[i].length; o.resp_error = 0;
        miss_q.delete(i);
        break;
      end
    end
    return o;
  endfunction

  task automatic send(tick_t t, logic typed, outcome_t want);
    outcome_t p;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.req_valid <= t.req_valid; tick_ch.req_write <= t.req_write;
    tick_ch.req_addr <= t.req_addr; tick_ch.req_length <= t.req_length;
    tick_ch.fill_valid <= t.fill_valid; tick_ch.fill_addr <= t.fill_addr;
    do @(posedge clk); while (!tick_ch.ready);
    p = cache_tick(t);
    outcome_q.insert(outcome_q.size(), typed ? want : p);
  endtask

  // addresses in a few sets so hits, evictions and queue-full occur
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    a = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      a[OB+RB-1:OB] = RB'($urandom_range(0, 3));
      a[31:OB+RB] = {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0} ^ 20'($urandom_range(0, 5));
    end
    return a;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int lo;
    t.req_valid = $urandom_range(0, 3) != 0;
    t.req_write = 1'($urandom);
    t.req_addr = pick_addr();
    lo = int'(t.req_addr[OB-1:0]);
    if ($urandom_range(0, 7) == 0) t.req_length = 8'($urandom);
    else t.req_length = 8'($urandom_range(1, LINE_BYTES - lo));
    t.fill_valid = $urandom_range(0, 2) == 0;
    if (t.fill_valid && miss_q.size() > 0 && $urandom_range(0, 1))
      t.fill_addr = miss_q[$urandom_range(0, miss_q.size() - 1)].addr ^ 32'($urandom_range(0, 63));
    else t.fill_addr = pick_addr();
    return t;
  endfunction

  function automatic outcome_t err_of(tick_t t);
    outcome_t o;
    o = '0;
    o.resp_valid = 1; o.resp_write = t.req_write; o.resp_addr = t.req_addr;
    o.resp_length = t.req_length; o.resp_error = 1;
    return o;
  endfunction

  function automatic tick_t mk(logic rv, logic rw, logic [31:0] ra, logic [7:0] rl,
                               logic fv, logic [31:0] fa);
    return '{rv, rw, ra, rl, fv, fa};
  endfunction

  // result sink with random stalls
  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.resp_valid, res_ch.resp_write, res_ch.resp_addr, res_ch.resp_length,
                res_ch.resp_error, res_ch.fetch_valid, res_ch.fetch_write, res_ch.fetch_addr};
        if (outcome_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (got.resp_valid !== want.resp_valid) begin
            $error("resp_valid exp %h got %h", want.resp_valid, got.resp_valid); errors++; end
          if (got.resp_write !== want.resp_write) begin
            $error("resp_write exp %h got %h", want.resp_write, got.resp_write); errors++; end
          if (got.resp_addr !== want.resp_addr) begin
            $error("resp_addr exp %h got %h", want.resp_addr, got.resp_addr); errors++; end
          if (got.resp_length !== want.resp_length) begin
            $error("resp_length exp %h got %h", want.resp_length, got.resp_length); errors++; end
          if (got.resp_error !== want.resp_error) begin
            $error("resp_error exp %h got %h", want.resp_error, got.resp_error); errors++; end
          if (got.fetch_valid !== want.fetch_valid) begin
            $error("fetch_valid exp %h got %h", want.fetch_valid, got.fetch_valid); errors++; end
          if (got.fetch_write !== want.fetch_write) begin
            $error("fetch_write exp %h got %h", want.fetch_write, got.fetch_write); errors++; end
          if (got.fetch_addr !== want.fetch_addr) begin
            $error("fetch_addr exp %h got %h", want.fetch_addr, got.fetch_addr); errors++; end
        end
      end
      if (draining || $urandom_range(0, 4) != 0) res_ch.ready <= 1'b1;
      else res_ch.ready <= ($urandom_range(0, 15) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    row_t tbl[$];
    tick_t t;
    outcome_t z;
    z = '0;
    tick_ch.valid = 1'b0; tick_ch.req_valid = 1'b0; tick_ch.req_write = 1'b0;
    tick_ch.req_addr = '0; tick_ch.req_length = '0; tick_ch.fill_valid = 1'b0;
    tick_ch.fill_addr = '0;
    for (int i = 0; i < NLINES; i++) begin lv[i] = 0; lt[i] = '0; la[i] = '0; end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty tick after reset
    tbl.insert(tbl.size(), '{mk(0, 0, 0, 0, 0, 0), 1, z});
    // malformed: zero length, too long, crossing, top of address space
    t = mk(1, 1, 32'h0000_1000, 0, 0, 0); tbl.insert(tbl.size(), '{t, 1, err_of(t)});
    t = mk(1, 0, 32'h0000_1000, 8'd65, 0, 0); tbl.insert(tbl.size(), '{t, 1, err_of(t)});
    t = mk(1, 1, 32'h0000_103F, 8'd2, 0, 0); tbl.insert(tbl.size(), '{t, 1, err_of(t)});
    t = mk(1, 0, 32'hFFFF_FFFF, 8'd255, 0, 0); tbl.insert(tbl.size(), '{t, 1, err_of(t)});
    // miss, then fill brings it in, then hit
    tbl.insert(tbl.size(), '{mk(1, 1, 32'hFFFF_FFC0, 8'd64, 0, 0), 0, z});
    tbl.insert(tbl.size(), '{mk(0, 0, 0, 0, 1, 32'hFFFF_FFFF), 0, z});
    tbl.insert(tbl.size(), '{mk(1, 0, 32'hFFFF_FFFF, 8'd1, 0, 0), 0, z});
    // miss and fill in the same tick
    tbl.insert(tbl.size(), '{mk(1, 0, 32'h0000_0000, 8'd1, 1, 32'h0000_0000), 0, z});
    // fill already present
    tbl.insert(tbl.size(), '{mk(0, 0, 0, 0, 1, 32'h0000_0010), 0, z});
    // five tags in one set: eviction of oldest
    for (int k = 1; k <= 5; k++)
      tbl.insert(tbl.size(), '{mk(0, 0, 0, 0, 1, 32'(k) << (OB + RB)), 0, z});
    // fill queue to full, then overflow, then queue-full response vs queued-answer conflict
    for (int k = 0; k < 9; k++)
      tbl.insert(tbl.size(),
                 '{mk(1, k[0], 32'h0000_0080 + (32'(k) << (OB + RB)), 8'd4, 0, 0), 0, z});
    tbl.insert(tbl.size(), '{mk(1, 0, 32'h0000_0000, 8'd1, 1, 32'h0000_0080), 0, z});

    foreach (tbl[i]) send(tbl[i].t, tbl[i].typed, tbl[i].o);
    // hold off until all results are in
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
    for (int n = 0; n < N_RANDOM; n++) begin
      send(rand_tick(), 0, z);
      if (n == N_RANDOM / 2) begin
        tick_ch.valid <= 1'b0;
        do @(posedge clk); while (outcome_q.size() != 0);
      end
    end

    tick_ch.valid <= 1'b0;
    draining <= 1'b1;
    do @(posedge clk); while (outcome_q.size() != 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/sactl_pkg.sv
rtl/core/sactl_if.sv
rtl/core/sactl_ctrl.sv
rtl/core/sactl_dpath.sv
rtl/core/set_assoc_cache_tag_lru.sv
tb/tb_top.sv
